// ----- design/crc16_frame_builder_defines.svh -----
// Assertion macros shared by the frame builder RTL.
`ifndef CRC16_FRAME_BUILDER_DEFINES_SVH
`define CRC16_FRAME_BUILDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on clk_i, masked while rst_ni is low.
`define CRCFB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("crc16_frame_builder: assertion failed");
// Checked on clk_i at every edge, reset included.
`define CRCFB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("crc16_frame_builder: assertion failed");
`else
`define CRCFB_ASSERT(lbl, prop)
`define CRCFB_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- design/crcfb_pkg.sv -----
// Types, constants and the CRC byte update shared by the frame builder.
package crcfb_pkg;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_ARG    = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  control_byte;
    logic [15:0] sequence_req;
    logic [7:0]  channel;
    logic [15:0] opcode;
    logic [7:0]  arg_count;
    logic [7:0]  arg_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_item_t;

  // One queued job: the item plus whether the CRC follows it.
  typedef struct packed {
    in_item_t item;
    logic     fin;
  } entry_t;

  typedef logic [3:0] slot_t;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SYNC_HI  = 8'hAA;
  localparam logic [7:0]  SYNC_LO  = 8'h55;
  localparam logic [15:0] LEN_ADD  = 16'd7;
  localparam logic [7:0]  DLEN_ADD = 8'd3;

  // Byte positions within a frame; an argument byte uses SLOT_ARG.
  localparam slot_t SLOT_SYNC_HI = 4'd0;
  localparam slot_t SLOT_SYNC_LO = 4'd1;
  localparam slot_t SLOT_LEN_HI  = 4'd2;
  localparam slot_t SLOT_LEN_LO  = 4'd3;
  localparam slot_t SLOT_CTRL    = 4'd4;
  localparam slot_t SLOT_SEQ_HI  = 4'd5;
  localparam slot_t SLOT_SEQ_LO  = 4'd6;
  localparam slot_t SLOT_DLEN    = 4'd7;
  localparam slot_t SLOT_CHAN    = 4'd8;
  localparam slot_t SLOT_OPC_HI  = 4'd9;
  localparam slot_t SLOT_OPC_LO  = 4'd10;
  localparam slot_t SLOT_ARG     = 4'd10;
  localparam slot_t SLOT_CRC_HI  = 4'd11;
  localparam slot_t SLOT_CRC_LO  = 4'd12;

  // CRC-16, MSB first, one byte.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      if (c[15] ^ b[k]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- design/crcfb_front.sv -----
// Front end: accepts items, tracks the open frame, drops stray arguments.
module crcfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  crcfb_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output crcfb_pkg::entry_t push_entry_o
);

  logic       in_frame_q, in_frame_d;
  logic [7:0] left_q, left_d;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    in_frame_d        = in_frame_q;
    left_d            = left_q;
    push_o            = 1'b0;
    push_entry_o.item = in_data_i;
    push_entry_o.fin  = 1'b0;
    if (accept) begin
      if (in_data_i.op == crcfb_pkg::OP_HEADER) begin
        // A new header abandons any open frame.
        push_o           = 1'b1;
        push_entry_o.fin = (in_data_i.arg_count == 8'd0);
        in_frame_d       = (in_data_i.arg_count != 8'd0);
        left_d           = in_data_i.arg_count;
      end else if (in_frame_q) begin
        push_o           = 1'b1;
        push_entry_o.fin = (left_q == 8'd1);
        in_frame_d       = (left_q != 8'd1);
        left_d           = left_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      left_q     <= 8'd0;
    end else begin
      in_frame_q <= in_frame_d;
      left_q     <= left_d;
    end
  end

endmodule

// ----- design/crcfb_queue.sv -----
// Small FIFO of jobs between the front and back ends.
`include "crc16_frame_builder_defines.svh"

module crcfb_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crcfb_pkg::entry_t push_entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output crcfb_pkg::entry_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  crcfb_pkg::entry_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `CRCFB_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH))
  `CRCFB_ASSERT(a_no_push_full, push_i |-> !full_o || pop_i)
  `CRCFB_ASSERT(a_no_pop_empty, pop_i |-> valid_o)

endmodule

// ----- design/crcfb_back.sv -----
// Back end: serializes each job into bytes, keeps the CRC, holds the output.
`include "crc16_frame_builder_defines.svh"

module crcfb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  crcfb_pkg::entry_t    q_head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output crcfb_pkg::out_item_t out_data_o
);

  crcfb_pkg::slot_t     step_q, step_d, slot, last_slot;
  logic [15:0]          crc_q, crc_d, len;
  logic [7:0]           dlen, cur_byte;
  logic                 out_valid_q;
  crcfb_pkg::out_item_t out_q;
  logic                 advance, emit, last, is_hdr;

  assign is_hdr    = (q_head_i.item.op == crcfb_pkg::OP_HEADER);
  assign slot      = is_hdr ? step_q : step_q + crcfb_pkg::SLOT_ARG;
  assign last_slot = q_head_i.fin ? crcfb_pkg::SLOT_CRC_LO : crcfb_pkg::SLOT_ARG;
  assign last      = (slot == last_slot);
  assign advance   = !out_valid_q || !out_stall_i;
  assign emit      = q_valid_i && advance;
  assign pop_o     = emit && last;
  assign len       = {8'd0, q_head_i.item.arg_count} + crcfb_pkg::LEN_ADD;
  assign dlen      = q_head_i.item.arg_count + crcfb_pkg::DLEN_ADD;

  always_comb begin
    case (slot)
      crcfb_pkg::SLOT_SYNC_HI: cur_byte = crcfb_pkg::SYNC_HI;
      crcfb_pkg::SLOT_SYNC_LO: cur_byte = crcfb_pkg::SYNC_LO;
      crcfb_pkg::SLOT_LEN_HI:  cur_byte = len[15:8];
      crcfb_pkg::SLOT_LEN_LO:  cur_byte = len[7:0];
      crcfb_pkg::SLOT_CTRL:    cur_byte = q_head_i.item.control_byte;
      crcfb_pkg::SLOT_SEQ_HI:  cur_byte = q_head_i.item.sequence_req[15:8];
      crcfb_pkg::SLOT_SEQ_LO:  cur_byte = q_head_i.item.sequence_req[7:0];
      crcfb_pkg::SLOT_DLEN:    cur_byte = dlen;
      crcfb_pkg::SLOT_CHAN:    cur_byte = q_head_i.item.channel;
      crcfb_pkg::SLOT_OPC_HI:  cur_byte = q_head_i.item.opcode[15:8];
      crcfb_pkg::SLOT_OPC_LO:  cur_byte = is_hdr ? q_head_i.item.opcode[7:0]
                                                 : q_head_i.item.arg_byte;
      crcfb_pkg::SLOT_CRC_HI:  cur_byte = crc_q[15:8];
      crcfb_pkg::SLOT_CRC_LO:  cur_byte = crc_q[7:0];
      default:                 cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    crc_d  = crc_q;
    if (emit) begin
      step_d = last ? '0 : step_q + crcfb_pkg::slot_t'(1);
      if (is_hdr && slot == crcfb_pkg::SLOT_SYNC_HI) begin
        crc_d = crcfb_pkg::CRC_INIT;
      end else if (slot >= crcfb_pkg::SLOT_CTRL && slot <= crcfb_pkg::SLOT_ARG) begin
        crc_d = crcfb_pkg::crc_feed(crc_q, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      crc_q       <= crcfb_pkg::CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      crc_q  <= crc_d;
      if (advance) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte  <= cur_byte;
      out_q.frame_end <= (slot == crcfb_pkg::SLOT_CRC_LO);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CRCFB_ASSERT(a_idle_step, !q_valid_i |-> step_q == '0)
  `CRCFB_ASSERT(a_emit_valid, emit |=> out_valid_q)

endmodule

// ----- design/crc16_frame_builder.sv -----
// Top level of the CRC-16 framed command serializer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------
//  in      | input     | in_valid_i/in_stall_o  | in_data_i  (in_item_t)
//  out     | output    | out_valid_o/out_stall_i| out_data_o (out_item_t)
//
// The front end takes one item per cycle while the job queue has room;
//   the back end sends one byte per cycle unless out_stall_i holds it, so
//   a header gives 11 bytes (13 with no arguments), an argument 1 (3 if last).
// Throughput is set by the back-end byte serializer and its output register.
// Reset clears the frame tracking, the queue pointers and the output valid
//   flag and loads CRC_INIT into the CRC; no clearing pass is needed.
// out_stall_i holds the output register; the queue then fills and in_stall_o
//   rises only when QUEUE_DEPTH jobs are waiting.
module crc16_frame_builder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  crcfb_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output crcfb_pkg::out_item_t out_data_o
);

  // Jobs flow front -> queue -> back.
  logic              push, q_full, q_valid, pop;
  crcfb_pkg::entry_t push_entry, q_head;

  // Classify each transaction; drop arguments outside a frame.
  crcfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Decouple item intake from byte serialization.
  crcfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  // Serialize bytes, run the CRC, append it at frame end.
  crcfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
